>>> rtl/line_rasterizer_unit_macros.svh
// ----------------------------------------------------------------------------
// line_rasterizer_unit_macros.svh
// Assertion shorthands shared by the line rasterizer checkers.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_UNIT_MACROS_SVH
`define LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int CLIP_BITS    = 13;
    localparam int ADDR_BITS    = 24;
    localparam int COLOR_BITS   = 32;
    localparam int CFG_IDX_BITS = 4;

    localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RST  = 13'd1600;
    localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RST = 13'd1200;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_HEIGHT = 4'd1;

    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_STEP  = 1'b1
    } func_t;

    // control part of a queued command
    typedef struct packed {
        func_t kind;
        logic  step_x_neg;
        logic  step_y_neg;
    } cmd_ctl_t;

    // per-pixel flags between stepper and output stage
    typedef struct packed {
        logic in_clip;
        logic last;
    } pix_flags_t;

endpackage

>>> rtl/lr_if.sv
// ----------------------------------------------------------------------------
// lr_if
// Channel interfaces: command words in, configuration writes, pixel words out.
// ----------------------------------------------------------------------------
interface lr_cmd_if #(parameter int COORD_BITS = 13);
    import lr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         func;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
    logic [COLOR_BITS-1:0]        line_color;

    modport source (output valid, func, x_start, y_start, x_end, y_end, line_color,
                    input ready);
    modport sink   (input valid, func, x_start, y_start, x_end, y_end, line_color,
                    output ready);
endinterface

interface lr_cfg_if;
    import lr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [CLIP_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface lr_pix_if #(parameter int COORD_BITS = 13);
    import lr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]         pixel_addr;
    logic [COLOR_BITS-1:0]        pixel_color;
    logic                         write_enable;
    logic                         last;

    modport source (output valid, pixel_x, pixel_y, pixel_addr, pixel_color, write_enable,
                    last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_addr, pixel_color, write_enable,
                    last, output ready);
endinterface

>>> rtl/line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// line_rasterizer_unit
// Bresenham line stepper with clip and linear framebuffer address.
//
//   channel | dir | words
//   --------+-----+------------------------------------------------------
//   cmd     | in  | func 0 = start line (endpoints, color), func 1 = step
//   cfg     | in  | index 0 = clip_width, index 1 = clip_height
//   pix     | out | x, y, addr, color, write_enable, last per step word
//
// One word per clock sustained on cmd and pix while pix is not stalled; every
// step word on an active line yields one pixel word, other words yield none.
// From cmd accept to pix valid a word passes the queue, then the stepper
// register and then the address/output register (one 13x13 multiply + add).
// rst_n is asynchronous: clears the queue, the active-line flag and the
// output valid; clip registers return to 1600 x 1200.
// Backpressure on pix stalls the stepper only when it holds a pixel; the
// two-entry queue keeps cmd flowing until it fills.
// ----------------------------------------------------------------------------
module line_rasterizer_unit #(
    parameter int COORD_BITS = 13
) (
    input logic      clk,
    input logic      rst_n,
    lr_cmd_if.sink   cmd,
    lr_cfg_if.sink   cfg,
    lr_pix_if.source pix
);
    import lr_pkg::*;

    localparam int DW    = COORD_BITS + 1;
    localparam int EW    = COORD_BITS + 3;
    localparam int CMD_W = $bits(cmd_ctl_t) + 4 * COORD_BITS + 2 * DW + EW + COLOR_BITS;

    // front -> queue
    logic                         f_valid;
    logic                         f_ready;
    cmd_ctl_t                     f_ctl;
    logic signed [COORD_BITS-1:0] f_x0;
    logic signed [COORD_BITS-1:0] f_y0;
    logic signed [COORD_BITS-1:0] f_x1;
    logic signed [COORD_BITS-1:0] f_y1;
    logic signed [DW-1:0]         f_dx;
    logic signed [DW-1:0]         f_ndy;
    logic signed [EW-1:0]         f_err;
    logic [COLOR_BITS-1:0]        f_color;
    logic [CMD_W-1:0]             push_word;

    // queue -> stepper
    logic                         q_valid;
    logic                         q_ready;
    logic [CMD_W-1:0]             pop_word;
    cmd_ctl_t                     b_ctl;
    logic signed [COORD_BITS-1:0] b_x0;
    logic signed [COORD_BITS-1:0] b_y0;
    logic signed [COORD_BITS-1:0] b_x1;
    logic signed [COORD_BITS-1:0] b_y1;
    logic signed [DW-1:0]         b_dx;
    logic signed [DW-1:0]         b_ndy;
    logic signed [EW-1:0]         b_err;
    logic [COLOR_BITS-1:0]        b_color;

    // stepper -> output stage
    logic                         s_valid;
    logic                         s_ready;
    logic signed [COORD_BITS-1:0] s_x;
    logic signed [COORD_BITS-1:0] s_y;
    logic [COLOR_BITS-1:0]        s_color;
    pix_flags_t                   s_flags;

    logic [CLIP_BITS-1:0]         clip_width;
    logic [CLIP_BITS-1:0]         clip_height;

    lr_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (cmd.valid),
        .in_ready    (cmd.ready),
        .in_func     (cmd.func),
        .x_start     (cmd.x_start),
        .y_start     (cmd.y_start),
        .x_end       (cmd.x_end),
        .y_end       (cmd.y_end),
        .line_color  (cmd.line_color),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .clip_width  (clip_width),
        .clip_height (clip_height),
        .push_valid  (f_valid),
        .push_ready  (f_ready),
        .ctl         (f_ctl),
        .x0          (f_x0),
        .y0          (f_y0),
        .x1          (f_x1),
        .y1          (f_y1),
        .delta_x     (f_dx),
        .neg_delta_y (f_ndy),
        .error_init  (f_err),
        .color       (f_color)
    );

    // queue word layout: control, endpoints, Bresenham terms, color
    assign push_word = {f_ctl, f_x0, f_y0, f_x1, f_y1, f_dx, f_ndy, f_err, f_color};

    lr_cmd_fifo #(.WIDTH(CMD_W)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (push_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (pop_word)
    );

    assign {b_ctl, b_x0, b_y0, b_x1, b_y1, b_dx, b_ndy, b_err, b_color} = pop_word;

    lr_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (q_valid),
        .cmd_ready   (q_ready),
        .ctl         (b_ctl),
        .x0          (b_x0),
        .y0          (b_y0),
        .x1          (b_x1),
        .y1          (b_y1),
        .delta_x     (b_dx),
        .neg_delta_y (b_ndy),
        .error_init  (b_err),
        .color       (b_color),
        .clip_width  (clip_width),
        .clip_height (clip_height),
        .pix_valid   (s_valid),
        .pix_ready   (s_ready),
        .pix_x       (s_x),
        .pix_y       (s_y),
        .pix_color   (s_color),
        .pix_flags   (s_flags)
    );

    lr_pix_out #(.COORD_BITS(COORD_BITS)) u_pix_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_x         (s_x),
        .in_y         (s_y),
        .in_color     (s_color),
        .in_flags     (s_flags),
        .clip_width   (clip_width),
        .out_valid    (pix.valid),
        .out_ready    (pix.ready),
        .pixel_x      (pix.pixel_x),
        .pixel_y      (pix.pixel_y),
        .pixel_addr   (pix.pixel_addr),
        .pixel_color  (pix.pixel_color),
        .write_enable (pix.write_enable),
        .last         (pix.last)
    );

endmodule

>>> rtl/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// Takes command words and config writes; sets up Bresenham terms on start.
// ----------------------------------------------------------------------------
module lr_front #(
    parameter int COORD_BITS = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_func,
    input  logic signed [COORD_BITS-1:0]      x_start,
    input  logic signed [COORD_BITS-1:0]      y_start,
    input  logic signed [COORD_BITS-1:0]      x_end,
    input  logic signed [COORD_BITS-1:0]      y_end,
    input  logic [lr_pkg::COLOR_BITS-1:0]     line_color,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [lr_pkg::CLIP_BITS-1:0]      cfg_data,
    output logic [lr_pkg::CLIP_BITS-1:0]      clip_width,
    output logic [lr_pkg::CLIP_BITS-1:0]      clip_height,
    output logic                              push_valid,
    input  logic                              push_ready,
    output lr_pkg::cmd_ctl_t                  ctl,
    output logic signed [COORD_BITS-1:0]      x0,
    output logic signed [COORD_BITS-1:0]      y0,
    output logic signed [COORD_BITS-1:0]      x1,
    output logic signed [COORD_BITS-1:0]      y1,
    output logic signed [COORD_BITS:0]        delta_x,
    output logic signed [COORD_BITS:0]        neg_delta_y,
    output logic signed [COORD_BITS+2:0]      error_init,
    output logic [lr_pkg::COLOR_BITS-1:0]     color
);
    import lr_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    logic [CLIP_BITS-1:0] clip_width_reg;
    logic [CLIP_BITS-1:0] clip_height_reg;
    logic signed [DW-1:0] dx_s;
    logic signed [DW-1:0] dy_s;

    // config writes; any other index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_width_reg  <= CLIP_WIDTH_RST;
            clip_height_reg <= CLIP_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_CLIP_WIDTH)
            begin
                clip_width_reg <= cfg_data;
            end
            if (cfg_index == CFG_CLIP_HEIGHT)
            begin
                clip_height_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready   = 1'b1;
    assign clip_width  = clip_width_reg;
    assign clip_height = clip_height_reg;

    // setup arithmetic; the result only matters on a start word
    assign dx_s = DW'(x_end) - DW'(x_start);
    assign dy_s = DW'(y_end) - DW'(y_start);

    assign delta_x     = dx_s[DW-1] ? -dx_s : dx_s;
    assign neg_delta_y = dy_s[DW-1] ? dy_s : -dy_s;
    assign error_init  = EW'(delta_x) + EW'(neg_delta_y);

    assign ctl.kind       = func_t'(in_func);
    assign ctl.step_x_neg = dx_s[DW-1] | (dx_s == '0);
    assign ctl.step_y_neg = dy_s[DW-1] | (dy_s == '0);

    assign x0    = x_start;
    assign y0    = y_start;
    assign x1    = x_end;
    assign y1    = y_end;
    assign color = line_color;

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

>>> rtl/lr_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lr_cmd_fifo
// Two-entry command queue between front and stepper.
// ----------------------------------------------------------------------------
module lr_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push & ~pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop & ~push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back
// Bresenham stepper: holds the line state, one pixel per active step word.
// ----------------------------------------------------------------------------
module lr_back #(
    parameter int COORD_BITS = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  lr_pkg::cmd_ctl_t                  ctl,
    input  logic signed [COORD_BITS-1:0]      x0,
    input  logic signed [COORD_BITS-1:0]      y0,
    input  logic signed [COORD_BITS-1:0]      x1,
    input  logic signed [COORD_BITS-1:0]      y1,
    input  logic signed [COORD_BITS:0]        delta_x,
    input  logic signed [COORD_BITS:0]        neg_delta_y,
    input  logic signed [COORD_BITS+2:0]      error_init,
    input  logic [lr_pkg::COLOR_BITS-1:0]     color,
    input  logic [lr_pkg::CLIP_BITS-1:0]      clip_width,
    input  logic [lr_pkg::CLIP_BITS-1:0]      clip_height,
    output logic                              pix_valid,
    input  logic                              pix_ready,
    output logic signed [COORD_BITS-1:0]      pix_x,
    output logic signed [COORD_BITS-1:0]      pix_y,
    output logic [lr_pkg::COLOR_BITS-1:0]     pix_color,
    output lr_pkg::pix_flags_t                pix_flags
);
    import lr_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;
    localparam int CW = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS;

    // line state
    logic signed [C-1:0]   cur_x_reg;
    logic signed [C-1:0]   cur_y_reg;
    logic signed [C-1:0]   goal_x_reg;
    logic signed [C-1:0]   goal_y_reg;
    logic signed [DW-1:0]  delta_x_reg;
    logic signed [DW-1:0]  neg_delta_y_reg;
    logic                  step_x_neg_reg;
    logic                  step_y_neg_reg;
    logic signed [EW-1:0]  error_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic                  active_reg;

    // pixel stage
    logic                  pix_valid_reg;
    logic signed [C-1:0]   pix_x_reg;
    logic signed [C-1:0]   pix_y_reg;
    logic [COLOR_BITS-1:0] pix_color_reg;
    pix_flags_t            pix_flags_reg;

    logic                  slot_free;
    logic                  is_start;
    logic                  take;
    logic                  emit;
    logic                  in_clip;
    logic                  at_end;
    logic signed [EW:0]    e2;
    logic                  go_x;
    logic                  go_y;
    logic signed [EW-1:0]  error_next;
    logic signed [C-1:0]   x_inc;
    logic signed [C-1:0]   y_inc;

    assign slot_free = ~pix_valid_reg | pix_ready;
    assign is_start  = (ctl.kind == FUNC_START);
    // a start or an idle step never needs the pixel slot
    assign cmd_ready = is_start | ~active_reg | slot_free;
    assign take      = cmd_valid & cmd_ready;
    assign emit      = take & ~is_start & active_reg;

    assign in_clip = ~cur_x_reg[C-1] & ~cur_y_reg[C-1]
                   & (CW'($unsigned(cur_x_reg)) < CW'(clip_width))
                   & (CW'($unsigned(cur_y_reg)) < CW'(clip_height));
    assign at_end = (cur_x_reg == goal_x_reg) & (cur_y_reg == goal_y_reg);

    assign e2   = {error_reg, 1'b0};
    assign go_x = (e2 >= (EW+1)'(neg_delta_y_reg));
    assign go_y = (e2 <= (EW+1)'(delta_x_reg));

    assign error_next = error_reg
                      + (go_x ? EW'(neg_delta_y_reg) : '0)
                      + (go_y ? EW'(delta_x_reg) : '0);

    assign x_inc = step_x_neg_reg ? {C{1'b1}} : C'(1);
    assign y_inc = step_y_neg_reg ? {C{1'b1}} : C'(1);

    always_ff @(posedge clk)
    begin
        if (take & is_start)
        begin
            cur_x_reg       <= x0;
            cur_y_reg       <= y0;
            goal_x_reg      <= x1;
            goal_y_reg      <= y1;
            delta_x_reg     <= delta_x;
            neg_delta_y_reg <= neg_delta_y;
            step_x_neg_reg  <= ctl.step_x_neg;
            step_y_neg_reg  <= ctl.step_y_neg;
            error_reg       <= error_init;
            color_reg       <= color;
        end
        else if (emit & ~at_end)
        begin
            error_reg <= error_next;
            if (go_x)
            begin
                cur_x_reg <= cur_x_reg + x_inc;
            end
            if (go_y)
            begin
                cur_y_reg <= cur_y_reg + y_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (take & is_start)
            begin
                active_reg <= 1'b1;
            end
            else if (emit & at_end)
            begin
                active_reg <= 1'b0;
            end

            if (emit)
            begin
                pix_valid_reg <= 1'b1;
            end
            else if (pix_ready)
            begin
                pix_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_x_reg             <= cur_x_reg;
            pix_y_reg             <= cur_y_reg;
            pix_color_reg         <= color_reg;
            pix_flags_reg.in_clip <= in_clip;
            pix_flags_reg.last    <= at_end;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix_x     = pix_x_reg;
    assign pix_y     = pix_y_reg;
    assign pix_color = pix_color_reg;
    assign pix_flags = pix_flags_reg;

endmodule

>>> rtl/lr_pix_out.sv
// ----------------------------------------------------------------------------
// lr_pix_out
// Output register: forms the linear address and holds the pixel word.
// ----------------------------------------------------------------------------
module lr_pix_out #(
    parameter int COORD_BITS = 13
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_BITS-1:0]      in_x,
    input  logic signed [COORD_BITS-1:0]      in_y,
    input  logic [lr_pkg::COLOR_BITS-1:0]     in_color,
    input  lr_pkg::pix_flags_t                in_flags,
    input  logic [lr_pkg::CLIP_BITS-1:0]      clip_width,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COORD_BITS-1:0]      pixel_x,
    output logic signed [COORD_BITS-1:0]      pixel_y,
    output logic [lr_pkg::ADDR_BITS-1:0]      pixel_addr,
    output logic [lr_pkg::COLOR_BITS-1:0]     pixel_color,
    output logic                              write_enable,
    output logic                              last
);
    import lr_pkg::*;

    localparam int PW = (COORD_BITS + CLIP_BITS + 1 > ADDR_BITS) ?
                        (COORD_BITS + CLIP_BITS + 1) : ADDR_BITS;

    logic                         valid_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic [ADDR_BITS-1:0]         addr_reg;
    logic [COLOR_BITS-1:0]        color_reg;
    logic                         we_reg;
    logic                         last_reg;
    logic                         load;
    logic [PW-1:0]                lin;

    assign in_ready = ~valid_reg | out_ready;
    assign load     = in_valid & in_ready;

    // y * stride + x; only meaningful inside the clip rectangle
    assign lin = PW'($unsigned(in_y)) * PW'(clip_width) + PW'($unsigned(in_x));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg     <= in_x;
            y_reg     <= in_y;
            addr_reg  <= in_flags.in_clip ? lin[ADDR_BITS-1:0] : '0;
            color_reg <= in_color;
            we_reg    <= in_flags.in_clip;
            last_reg  <= in_flags.last;
        end
    end

    assign out_valid    = valid_reg;
    assign pixel_x      = x_reg;
    assign pixel_y      = y_reg;
    assign pixel_addr   = addr_reg;
    assign pixel_color  = color_reg;
    assign write_enable = we_reg;
    assign last         = last_reg;

endmodule

>>> rtl/lr_chk.sv
// ----------------------------------------------------------------------------
// lr_chk
// Port-level checks on the pixel channel of the line rasterizer.
// ----------------------------------------------------------------------------
`include "line_rasterizer_unit_macros.svh"

module lr_chk #(
    parameter int COORD_BITS = 13
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [COORD_BITS-1:0]  pixel_x,
    input logic signed [COORD_BITS-1:0]  pixel_y,
    input logic [lr_pkg::ADDR_BITS-1:0]  pixel_addr,
    input logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
    input logic                          write_enable,
    input logic                          last
);
    import lr_pkg::*;

    // clipped pixels carry a zero address
    `LR_ASSERT_IMPLY(a_addr_zero_clipped, clk, rst_n, out_valid && !write_enable, pixel_addr == '0, "clipped pixel with nonzero address")

    // a written pixel never has a negative coordinate
    `LR_ASSERT_IMPLY(a_we_nonneg, clk, rst_n, out_valid && write_enable, !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1], "write enable on negative coordinate")

    // on row zero the address is just x
    `LR_ASSERT_IMPLY(a_row0_addr, clk, rst_n, out_valid && write_enable && pixel_y == '0, pixel_addr == ADDR_BITS'($unsigned(pixel_x)), "row zero address mismatch")

    // stalled pixel word holds
    `LR_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_addr) && $stable(pixel_color) && $stable(write_enable) && $stable(last), "pixel word changed under stall")

endmodule

bind line_rasterizer_unit lr_chk #(.COORD_BITS(COORD_BITS)) u_lr_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (pix.valid),
    .out_ready    (pix.ready),
    .pixel_x      (pix.pixel_x),
    .pixel_y      (pix.pixel_y),
    .pixel_addr   (pix.pixel_addr),
    .pixel_color  (pix.pixel_color),
    .write_enable (pix.write_enable),
    .last         (pix.last)
);

>>> sim/line_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_pixel_checker
// Watches the command, configuration and pixel channels. Runs its own
// Bresenham stepper on every accepted command word, queues the pixel words
// it predicts and compares each accepted pixel word against the oldest one.
// ----------------------------------------------------------------------------
module line_pixel_checker #(
    parameter int COORD_BITS = 13
) (
    input  logic clk,
    input  logic rst_n,
    lr_cmd_if    cmd,
    lr_cfg_if    cfg,
    lr_pix_if    pix,
    output int   mismatches,
    output int   pixels_due
);
    import lr_pkg::*;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [ADDR_BITS-1:0]         addr;
        logic [COLOR_BITS-1:0]        color;
        logic                         write_enable;
        logic                         last;
    } pixel_word_t;

    // predicted stepper state
    logic [CLIP_BITS-1:0]         clip_w;
    logic [CLIP_BITS-1:0]         clip_h;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COORD_BITS:0]          run_x;     // |dx|
    logic signed [COORD_BITS:0]   rise_neg;  // -|dy|
    logic                         dir_x_neg;
    logic                         dir_y_neg;
    logic signed [COORD_BITS+2:0] err;
    logic [COLOR_BITS-1:0]        color_now;
    logic                         line_active;

    pixel_word_t pixel_queue[$];
    pixel_word_t oldest;
    int          err_count;

    task automatic load_line(input logic signed [COORD_BITS-1:0] x0, y0, x1, y1,
                             input logic [COLOR_BITS-1:0] color);
        int dx;
        int dy;
        dx = int'(x1) - int'(x0);
        dy = int'(y1) - int'(y0);
        pos_x       = x0;
        pos_y       = y0;
        end_x       = x1;
        end_y       = y1;
        run_x       = (COORD_BITS+1)'(dx < 0 ? -dx : dx);
        rise_neg    = (COORD_BITS+1)'(dy < 0 ? dy : -dy);
        dir_x_neg   = !(int'(x0) < int'(x1));
        dir_y_neg   = !(int'(y0) < int'(y1));
        err         = (COORD_BITS+3)'(int'(run_x) + int'(rise_neg));
        color_now   = color;
        line_active = 1'b1;
    endtask

    // emit the current pixel, then take one Bresenham step
    task automatic trace_pixel();
        pixel_word_t px;
        int          cx;
        int          cy;
        int          e2;
        bit          in_clip;
        cx = int'(pos_x);
        cy = int'(pos_y);
        in_clip = cx >= 0 && cx < int'(clip_w) && cy >= 0 && cy < int'(clip_h);
        px.x            = pos_x;
        px.y            = pos_y;
        px.color        = color_now;
        px.write_enable = in_clip;
        px.last         = (pos_x == end_x) && (pos_y == end_y);
        px.addr         = in_clip ?
                          ADDR_BITS'(longint'(cy) * longint'(clip_w) + longint'(cx)) : '0;
        pixel_queue = {pixel_queue, px};
        if (px.last)
        begin
            line_active = 1'b0;
        end
        else
        begin
            e2 = 2 * int'(err);
            if (e2 >= int'(rise_neg))
            begin
                err   = (COORD_BITS+3)'(int'(err) + int'(rise_neg));
                pos_x = COORD_BITS'(cx + (dir_x_neg ? -1 : 1));
            end
            if (e2 <= int'(run_x))
            begin
                err   = (COORD_BITS+3)'(int'(err) + int'(run_x));
                pos_y = COORD_BITS'(cy + (dir_y_neg ? -1 : 1));
            end
        end
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want, got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_w      = CLIP_WIDTH_RST;
            clip_h      = CLIP_HEIGHT_RST;
            pos_x       = '0;
            pos_y       = '0;
            end_x       = '0;
            end_y       = '0;
            run_x       = '0;
            rise_neg    = '0;
            dir_x_neg   = 1'b0;
            dir_y_neg   = 1'b0;
            err         = '0;
            color_now   = '0;
            line_active = 1'b0;
            err_count   = 0;
            pixel_queue.delete();
            mismatches <= 0;
            pixels_due <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_CLIP_WIDTH)
                    clip_w = cfg.data;
                else if (cfg.index == CFG_CLIP_HEIGHT)
                    clip_h = cfg.data;
            end

            if (pix.valid && pix.ready)
            begin
                if (pixel_queue.size() == 0)
                begin
                    err_count++;
                    $display("%0t ns: expected no pixel word, actual (%0d, %0d)",
                             $time, pix.pixel_x, pix.pixel_y);
                end
                else
                begin
                    oldest = pixel_queue.pop_front();
                    check_field("pixel_x", oldest.x, pix.pixel_x);
                    check_field("pixel_y", oldest.y, pix.pixel_y);
                    check_field("pixel_addr", oldest.addr, pix.pixel_addr);
                    check_field("pixel_color", oldest.color, pix.pixel_color);
                    check_field("write_enable", oldest.write_enable, pix.write_enable);
                    check_field("last", oldest.last, pix.last);
                end
            end

            if (cmd.valid && cmd.ready)
            begin
                if (func_t'(cmd.func) == FUNC_START)
                    load_line(cmd.x_start, cmd.y_start, cmd.x_end, cmd.y_end, cmd.line_color);
                else if (line_active)
                    trace_pixel();
            end

            mismatches <= err_count;
            pixels_due <= pixel_queue.size();
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives line_rasterizer_unit with start and step words under random stalls
// on both sides, walks the clip registers through several sizes, and takes
// the verdict from the pixel checker running beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import lr_pkg::*;

    localparam int COORD_BITS = 13;
    localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));
    localparam int IDLE_LIMIT = 2000;  // cycles with no handshake on any channel
    localparam int DRAIN_TAIL = 8;     // extra wait at the end of drain_pixels

    // indexes past the two clip registers; the block must ignore them
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 4'd15;

    logic clk = 1'b0;
    logic rst_n;

    int mismatch_count;
    int pixels_due;
    int quiet_cycles = 0;

    // current clip size as the stimulus sees it, for aiming lines at the edges
    int clip_w_now = 1600;
    int clip_h_now = 1200;

    // set while the sender runs a burst with no gaps
    bit tx_calm = 1'b0;

    lr_cmd_if #(.COORD_BITS(COORD_BITS)) cmd_ch ();
    lr_cfg_if                            cfg_ch ();
    lr_pix_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

    line_rasterizer_unit #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch),
        .cfg  (cfg_ch),
        .pix  (pix_ch)
    );

    line_pixel_checker #(
        .COORD_BITS(COORD_BITS)
    ) pixel_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .cfg       (cfg_ch),
        .pix       (pix_ch),
        .mismatches(mismatch_count),
        .pixels_due(pixels_due)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: a healthy run never goes this long without some handshake,
    // even with the longest stalls on both sides.
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (pix_ch.valid && pix_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Pixel sink: holds ready low for a random stall before each word, with
    // calm stretches where ready stays high.
    initial
    begin : pixel_sink
        int stall;
        bit calm;
        calm = 1'b0;
        pix_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pix_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(pix_ch.valid && pix_ch.ready));
        end
    end

    function automatic int clamp_coord(input int v);
        return v > COORD_MAX ? COORD_MAX : (v < COORD_MIN ? COORD_MIN : v);
    endfunction

    // One command word. A random gap first (valid low), then hold the word
    // until accepted. Valid stays high on return so back-to-back words
    // stream at full rate when the next gap is zero.
    task automatic send_cmd(input func_t f, input int x0, y0, x1, y1,
                            input logic [COLOR_BITS-1:0] color);
        int gap;
        if ($urandom_range(0, 49) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.func       <= f;
        cmd_ch.x_start    <= COORD_BITS'(x0);
        cmd_ch.y_start    <= COORD_BITS'(y0);
        cmd_ch.x_end      <= COORD_BITS'(x1);
        cmd_ch.y_end      <= COORD_BITS'(y1);
        cmd_ch.line_color <= color;
        cmd_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    // step word; the endpoint and color fields are don't-care, so fill them
    // with noise
    task automatic send_step();
        send_cmd(FUNC_STEP, $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // Wait until every predicted pixel is out, then a few more cycles for
    // step words on no line that may still sit in the pipe.
    task automatic drain_pixels();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (pixels_due != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    // Only called with the block idle. Valid drops for one cycle afterwards
    // so two writes in a row never collide in one time step.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                             input logic [CLIP_BITS-1:0] data);
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (index == CFG_CLIP_WIDTH)
            clip_w_now = int'(data);
        else if (index == CFG_CLIP_HEIGHT)
            clip_h_now = int'(data);
        @(posedge clk);
    endtask

    // Pick endpoints. Most lines are short and start either anywhere in the
    // coordinate space or around the clip rectangle so both clip outcomes
    // show up. A few have both ends anywhere in the space and get cut off early.
    task automatic pick_endpoints(output int x0, y0, x1, y1, output bit far);
        int span;
        int mode;
        span = ($urandom_range(0, 3) == 0) ? 60 : 12;
        mode = $urandom_range(0, 19);
        far  = (mode == 0);
        if (far)
        begin
            x0 = int'($urandom_range(0, 8191)) + COORD_MIN;
            y0 = int'($urandom_range(0, 8191)) + COORD_MIN;
            x1 = int'($urandom_range(0, 8191)) + COORD_MIN;
            y1 = int'($urandom_range(0, 8191)) + COORD_MIN;
        end
        else
        begin
            if (mode < 8)
            begin
                x0 = int'($urandom_range(0, 8191)) + COORD_MIN;
                y0 = int'($urandom_range(0, 8191)) + COORD_MIN;
            end
            else
            begin
                x0 = clamp_coord(int'($urandom_range(0, clip_w_now + 40)) - 20);
                y0 = clamp_coord(int'($urandom_range(0, clip_h_now + 40)) - 20);
            end
            x1 = clamp_coord(x0 + int'($urandom_range(0, 2 * span)) - span);
            y1 = clamp_coord(y0 + int'($urandom_range(0, 2 * span)) - span);
        end
    endtask

    // Mostly complete lines: a start and exactly as many steps as the line
    // has pixels. About one in ten is cut short by the next start, and now
    // and then a step or two runs past the end of a finished line.
    task automatic run_lines(input int n);
        int done;
        int x0;
        int y0;
        int x1;
        int y1;
        int adx;
        int ady;
        int len;
        int cut;
        bit far;
        done = 0;
        while (done < n)
        begin
            pick_endpoints(x0, y0, x1, y1, far);
            send_cmd(FUNC_START, x0, y0, x1, y1, $urandom());
            done++;
            adx = x1 > x0 ? x1 - x0 : x0 - x1;
            ady = y1 > y0 ? y1 - y0 : y0 - y1;
            len = (adx > ady ? adx : ady) + 1;
            cut = len;
            if (far)
                cut = $urandom_range(1, 40);
            else if ($urandom_range(0, 9) == 0)
                cut = $urandom_range(0, len - 1);
            if (cut > len)
                cut = len;
            repeat (cut) send_step();
            done += cut;
            if (cut == len && $urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 2)) send_step();
        end
    endtask

    initial
    begin : stimulus
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.func       <= FUNC_START;
        cmd_ch.x_start    <= '0;
        cmd_ch.y_start    <= '0;
        cmd_ch.x_end      <= '0;
        cmd_ch.y_end      <= '0;
        cmd_ch.line_color <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= CFG_CLIP_WIDTH;
        cfg_ch.data       <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed, reset clip of 1600 x 1200 ----
        // step before any line: nothing comes out
        send_step();
        // single-point line: its only pixel is flagged last
        send_cmd(FUNC_START, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_step();
        // line already finished: nothing comes out
        send_step();
        // corner to corner across the whole space, outside the clip
        send_cmd(FUNC_START, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'h0000_0000);
        repeat (2) send_step();
        // replaces the long line; crosses the clip corner going out
        send_cmd(FUNC_START, 1599, 1199, 1601, 1197, 32'hA5A5_A5A5);
        repeat (3) send_step();
        // leftward run along the bottom edge of the space, cut short
        send_cmd(FUNC_START, COORD_MAX, COORD_MIN, COORD_MAX - 5, COORD_MIN, 32'h5A5A_5A5A);
        repeat (2) send_step();
        // vertical line, replaces the run above
        send_cmd(FUNC_START, 5, 3, 5, 9, 32'h1234_5678);
        repeat (7) send_step();

        // ---- random lines at the reset clip ----
        run_lines(300);

        // largest legal framebuffer
        drain_pixels();
        write_reg(CFG_CLIP_WIDTH, 13'd4096);
        write_reg(CFG_CLIP_HEIGHT, 13'd4096);
        run_lines(200);

        // all-ones registers: y * width overflows 24 bits, address wraps
        drain_pixels();
        write_reg(CFG_CLIP_WIDTH, 13'h1FFF);
        write_reg(CFG_CLIP_HEIGHT, 13'h1FFF);
        run_lines(150);

        // one-pixel framebuffer
        drain_pixels();
        write_reg(CFG_CLIP_WIDTH, 13'd1);
        write_reg(CFG_CLIP_HEIGHT, 13'd1);
        run_lines(100);

        // zero size clips every pixel
        drain_pixels();
        write_reg(CFG_CLIP_WIDTH, 13'd0);
        write_reg(CFG_CLIP_HEIGHT, 13'd0);
        run_lines(60);

        // writes to unused indexes must leave the zero clip alone
        drain_pixels();
        write_reg(CFG_UNUSED_LO, 13'h1FFF);
        write_reg(CFG_UNUSED_HI, 13'h0000);
        run_lines(20);

        // random sizes in the legal range
        drain_pixels();
        write_reg(CFG_CLIP_WIDTH, 13'($urandom_range(1, 4096)));
        write_reg(CFG_CLIP_HEIGHT, 13'($urandom_range(1, 4096)));
        run_lines(180);

        drain_pixels();
        write_reg(CFG_CLIP_WIDTH, 13'($urandom_range(1, 4096)));
        write_reg(CFG_CLIP_HEIGHT, 13'($urandom_range(1, 4096)));
        run_lines(200);

        drain_pixels();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
